### hdl/pfsl_pkg.sv
package pfsl_pkg;

    // Fixed widths of the corrections and of the fraction in Q15.16.
    localparam int CORR_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PHASES_DEF = 4;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_POS  = 2'd1,
        SIDE_NEG  = 2'd2
    } side_t;

endpackage

### hdl/pfsl_in_if.sv
interface pfsl_in_if import pfsl_pkg::*; #(
    parameter int PHASES = PHASES_DEF
) ();

    logic                           valid;
    logic                           ready;
    logic [PHASES-1:0][CORR_W-1:0]  corr;
    logic [PHASES-1:0]              fixed_mask;

    modport source (output valid, output corr, output fixed_mask, input ready);
    modport sink   (input valid, input corr, input fixed_mask, output ready);

endinterface

### hdl/pfsl_out_if.sv
interface pfsl_out_if import pfsl_pkg::*; #(
    parameter int PHASES = PHASES_DEF
) ();

    logic                           valid;
    logic                           ready;
    logic [PHASES-1:0][CORR_W-1:0]  limited;
    side_t                          scaled_side;
    logic                           saturated;

    modport source (output valid, output limited, output scaled_side, output saturated,
                    input ready);
    modport sink   (input valid, input limited, input scaled_side, input saturated,
                    output ready);

endinterface

### hdl/phase_flux_sum_limiter.sv
// Channel   Interface     Role    Word
// face      pfsl_in_if    sink    PHASES corrections (Q15.16) and the fixed-phase mask
// result    pfsl_out_if   source  PHASES limited corrections, scaled side, saturation flag
//
// One word is accepted in every cycle unless every stage is full and the output is
// stalled; each word passes the input register, the sum, side and magnitude stages,
// the restoring divider (an overflow stage, then one quotient bit per stage over
// 48 stages) and the split-multiply and output stages before the result appears.
// Reset clears only the stage valid bits; the data registers are loaded as words pass.
// A stage holds only while it and every stage after it are full, so bubbles close up and
// the input keeps being taken while a finished result waits, until every stage is full.
module phase_flux_sum_limiter import pfsl_pkg::*; #(
    parameter int PHASES = PHASES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pfsl_in_if.sink     face,
    pfsl_out_if.source  result
);

    localparam int SUM_W  = CORR_W + $clog2(PHASES);
    localparam int LAM_W  = CORR_W + FRAC_W;
    localparam int LO_W   = LAM_W / 2;
    localparam int HI_W   = LAM_W - LO_W;
    localparam int PROD_W = CORR_W + LAM_W;
    localparam int MAG_W  = PROD_W - FRAC_W;

    localparam int S_DIV0 = 4;
    localparam int S_M0   = S_DIV0 + LAM_W + 1;
    localparam int S_M1   = S_M0 + 1;
    localparam int S_M2   = S_M1 + 1;
    localparam int S_OUT  = S_M2 + 1;
    localparam int NS     = S_OUT + 1;

    localparam logic [CORR_W-1:0] MAX_POS = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic [CORR_W-1:0] MIN_NEG = {1'b1, {(CORR_W-1){1'b0}}};

    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [SUM_W-1:0]             mag_t;
    typedef logic [PHASES-1:0][CORR_W-1:0] corr_vec_t;

    typedef struct packed {
        corr_vec_t          corr;
        logic [PHASES-1:0]  mask;
        side_t              side;
        logic               lam_neg;
        logic               ovf;
        mag_t               den;
        mag_t               rem;
        logic [LAM_W-1:0]   sh;
    } div_t;

    // Handshake: a stage loads when it or some later stage has room, or the output is taken.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_in;
    logic [NS-1:0] en;

    assign v_in = {v_reg[NS-2:0], face.valid};

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            en[k] = result.ready || (((~v_reg) >> k) != '0);
        end
    end

    assign face.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    // Stage 0: input register.
    corr_vec_t         s0_corr_reg;
    logic [PHASES-1:0] s0_mask_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_corr_reg <= face.corr;
            s0_mask_reg <= face.fixed_mask;
        end
    end

    // Stage 1: positive, negative and fixed sums.
    corr_vec_t         s1_corr_reg;
    logic [PHASES-1:0] s1_mask_reg;
    sum_t              s1_pos_reg, s1_neg_reg, s1_fix_reg;
    sum_t              s1_pos_next, s1_neg_next, s1_fix_next;

    always_comb
    begin
        sum_t c;
        s1_pos_next = '0;
        s1_neg_next = '0;
        s1_fix_next = '0;
        for (int i = 0; i < PHASES; i++)
        begin
            c = sum_t'($signed(s0_corr_reg[i]));
            if (s0_mask_reg[i])
            begin
                s1_fix_next = s1_fix_next + c;
            end
            else if (c > 0)
            begin
                s1_pos_next = s1_pos_next + c;
            end
            else
            begin
                s1_neg_next = s1_neg_next + c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_corr_reg <= s0_corr_reg;
            s1_mask_reg <= s0_mask_reg;
            s1_pos_reg  <= s1_pos_next;
            s1_neg_reg  <= s1_neg_next;
            s1_fix_reg  <= s1_fix_next;
        end
    end

    // Stage 2: choose the side; s is the negated numerator.
    corr_vec_t         s2_corr_reg;
    logic [PHASES-1:0] s2_mask_reg;
    side_t             s2_side_reg, s2_side_next;
    sum_t              s2_s_reg, s2_s_next;
    sum_t              s2_den_reg, s2_den_next;

    always_comb
    begin
        sum_t total;
        total = s1_pos_reg + s1_neg_reg;
        if (total > 0)
        begin
            s2_side_next = SIDE_POS;
        end
        else if (total < 0)
        begin
            s2_side_next = SIDE_NEG;
        end
        else
        begin
            s2_side_next = SIDE_NONE;
        end
        if (total > 0)
        begin
            s2_s_next   = s1_neg_reg + s1_fix_reg;
            s2_den_next = s1_pos_reg;
        end
        else
        begin
            s2_s_next   = s1_pos_reg + s1_fix_reg;
            s2_den_next = s1_neg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_corr_reg <= s1_corr_reg;
            s2_mask_reg <= s1_mask_reg;
            s2_side_reg <= s2_side_next;
            s2_s_reg    <= s2_s_next;
            s2_den_reg  <= s2_den_next;
        end
    end

    // Stage 3: magnitudes and the sign of the scale factor.
    corr_vec_t         s3_corr_reg;
    logic [PHASES-1:0] s3_mask_reg;
    side_t             s3_side_reg;
    mag_t              s3_num_reg, s3_num_next;
    mag_t              s3_den_reg, s3_den_next;
    logic              s3_lneg_reg, s3_lneg_next;

    always_comb
    begin
        s3_num_next  = (s2_s_reg < 0) ? mag_t'(-s2_s_reg) : mag_t'(s2_s_reg);
        s3_den_next  = (s2_den_reg < 0) ? mag_t'(-s2_den_reg) : mag_t'(s2_den_reg);
        s3_lneg_next = (s2_side_reg == SIDE_POS) ? (s2_s_reg > 0) : (s2_s_reg < 0);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_corr_reg <= s2_corr_reg;
            s3_mask_reg <= s2_mask_reg;
            s3_side_reg <= s2_side_reg;
            s3_num_reg  <= s3_num_next;
            s3_den_reg  <= s3_den_next;
            s3_lneg_reg <= s3_lneg_next;
        end
    end

    // Divider. The quotient is needed only below 2^LAM_W: anything larger clips every
    // product, so it is flagged here and clamped to all ones afterwards.
    div_t d_reg  [0:LAM_W];
    div_t d_next [0:LAM_W];

    always_comb
    begin
        d_next[0].corr    = s3_corr_reg;
        d_next[0].mask    = s3_mask_reg;
        d_next[0].side    = s3_side_reg;
        d_next[0].lam_neg = s3_lneg_reg;
        d_next[0].ovf     = (s3_num_reg >> CORR_W) >= s3_den_reg;
        d_next[0].den     = s3_den_reg;
        d_next[0].rem     = mag_t'(s3_num_reg >> CORR_W);
        d_next[0].sh      = {s3_num_reg[CORR_W-1:0], {FRAC_W{1'b0}}};
    end

    for (genvar j = 1; j <= LAM_W; j++)
    begin : g_div
        logic [SUM_W:0] trial;
        logic           take;

        always_comb
        begin
            trial     = {d_reg[j-1].rem, d_reg[j-1].sh[LAM_W-1]};
            take      = trial >= {1'b0, d_reg[j-1].den};
            d_next[j] = d_reg[j-1];
            if (take)
            begin
                d_next[j].rem = mag_t'(trial - {1'b0, d_reg[j-1].den});
            end
            else
            begin
                d_next[j].rem = trial[SUM_W-1:0];
            end
            d_next[j].sh = {d_reg[j-1].sh[LAM_W-2:0], take};
        end
    end

    for (genvar j = 0; j <= LAM_W; j++)
    begin : g_div_reg
        always_ff @(posedge clk)
        begin
            if (en[S_DIV0+j])
            begin
                d_reg[j] <= d_next[j];
            end
        end
    end

    // M0: lane selection, correction magnitudes and the clamped scale factor.
    corr_vec_t         m0_corr_reg;
    logic [PHASES-1:0] m0_scal_reg, m0_scal_next;
    logic [PHASES-1:0] m0_neg_reg, m0_neg_next;
    corr_vec_t         m0_mc_reg, m0_mc_next;
    logic [LAM_W-1:0]  m0_qs_reg, m0_qs_next;
    side_t             m0_side_reg;

    always_comb
    begin
        logic cneg;
        logic cpos;
        m0_qs_next = d_reg[LAM_W].ovf ? '1 : d_reg[LAM_W].sh;
        for (int i = 0; i < PHASES; i++)
        begin
            cneg = d_reg[LAM_W].corr[i][CORR_W-1];
            cpos = !cneg && (d_reg[LAM_W].corr[i] != '0);
            m0_scal_next[i] = !d_reg[LAM_W].mask[i] &&
                              (((d_reg[LAM_W].side == SIDE_POS) && cpos) ||
                               ((d_reg[LAM_W].side == SIDE_NEG) && cneg));
            m0_neg_next[i]  = d_reg[LAM_W].lam_neg ^ cneg;
            m0_mc_next[i]   = cneg ? -d_reg[LAM_W].corr[i] : d_reg[LAM_W].corr[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_M0])
        begin
            m0_corr_reg <= d_reg[LAM_W].corr;
            m0_scal_reg <= m0_scal_next;
            m0_neg_reg  <= m0_neg_next;
            m0_mc_reg   <= m0_mc_next;
            m0_qs_reg   <= m0_qs_next;
            m0_side_reg <= d_reg[LAM_W].side;
        end
    end

    // M1: low partial product.
    corr_vec_t                          m1_corr_reg;
    logic [PHASES-1:0]                  m1_scal_reg, m1_neg_reg;
    corr_vec_t                          m1_mc_reg;
    logic [PHASES-1:0][CORR_W+LO_W-1:0] m1_plo_reg, m1_plo_next;
    logic [HI_W-1:0]                    m1_qhi_reg;
    side_t                              m1_side_reg;

    always_comb
    begin
        for (int i = 0; i < PHASES; i++)
        begin
            m1_plo_next[i] = (CORR_W+LO_W)'(m0_mc_reg[i]) *
                             (CORR_W+LO_W)'(m0_qs_reg[LO_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_M1])
        begin
            m1_corr_reg <= m0_corr_reg;
            m1_scal_reg <= m0_scal_reg;
            m1_neg_reg  <= m0_neg_reg;
            m1_mc_reg   <= m0_mc_reg;
            m1_plo_reg  <= m1_plo_next;
            m1_qhi_reg  <= m0_qs_reg[LAM_W-1:LO_W];
            m1_side_reg <= m0_side_reg;
        end
    end

    // M2: high partial product added in.
    corr_vec_t                     m2_corr_reg;
    logic [PHASES-1:0]             m2_scal_reg, m2_neg_reg;
    logic [PHASES-1:0][PROD_W-1:0] m2_prod_reg, m2_prod_next;
    side_t                         m2_side_reg;

    always_comb
    begin
        logic [CORR_W+HI_W-1:0] hi;
        for (int i = 0; i < PHASES; i++)
        begin
            hi = (CORR_W+HI_W)'(m1_mc_reg[i]) * (CORR_W+HI_W)'(m1_qhi_reg);
            m2_prod_next[i] = {hi, {LO_W{1'b0}}} + PROD_W'(m1_plo_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_M2])
        begin
            m2_corr_reg <= m1_corr_reg;
            m2_scal_reg <= m1_scal_reg;
            m2_neg_reg  <= m1_neg_reg;
            m2_prod_reg <= m2_prod_next;
            m2_side_reg <= m1_side_reg;
        end
    end

    // Output stage: drop the fraction, saturate, apply the sign.
    corr_vec_t out_lim_reg, out_lim_next;
    side_t     out_side_reg;
    logic      out_sat_reg, out_sat_next;

    always_comb
    begin
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  limit;
        logic [CORR_W-1:0] lo;
        out_sat_next = 1'b0;
        for (int i = 0; i < PHASES; i++)
        begin
            mag   = m2_prod_reg[i][PROD_W-1:FRAC_W];
            limit = MAG_W'(m2_neg_reg[i] ? MIN_NEG : MAX_POS);
            lo    = mag[CORR_W-1:0];
            if (!m2_scal_reg[i])
            begin
                out_lim_next[i] = m2_corr_reg[i];
            end
            else if (mag > limit)
            begin
                out_lim_next[i] = m2_neg_reg[i] ? MIN_NEG : MAX_POS;
                out_sat_next    = 1'b1;
            end
            else
            begin
                out_lim_next[i] = m2_neg_reg[i] ? -lo : lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            out_lim_reg  <= out_lim_next;
            out_side_reg <= m2_side_reg;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign result.valid       = v_reg[NS-1];
    assign result.limited     = out_lim_reg;
    assign result.scaled_side = out_side_reg;
    assign result.saturated   = out_sat_reg;

endmodule

### hdl/pfsl_checker.sv
module pfsl_checker import pfsl_pkg::*; #(
    parameter int PHASES = PHASES_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          face_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [PHASES-1:0][CORR_W-1:0] limited,
    input side_t                         scaled_side,
    input logic                          saturated
);

    localparam logic [CORR_W-1:0] MAX_POS = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic [CORR_W-1:0] MIN_NEG = {1'b1, {(CORR_W-1){1'b0}}};

    logic any_extreme;

    always_comb
    begin
        any_extreme = 1'b0;
        for (int i = 0; i < PHASES; i++)
        begin
            if ((limited[i] == MAX_POS) || (limited[i] == MIN_NEG))
            begin
                any_extreme = 1'b1;
            end
        end
    end

    // A waiting result holds its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(limited) && $stable(scaled_side) && $stable(saturated))
        else $error("result word changed while stalled");

    // With the output register empty there is always room at the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> face_ready)
        else $error("input stalled with an empty pipeline end");

    // Nothing can clip when no side is scaled.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (scaled_side == SIDE_NONE) |-> !saturated)
        else $error("saturation flagged with no side scaled");

    // A clipped product leaves a lane at one end of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> any_extreme)
        else $error("saturation flagged but no lane at a range limit");

endmodule

bind phase_flux_sum_limiter pfsl_checker #(.PHASES(PHASES)) u_pfsl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .face_ready   (face.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .limited      (result.limited),
    .scaled_side  (result.scaled_side),
    .saturated    (result.saturated)
);
